// ===== rtl/pkt_pkg.sv =====
// pkt_pkg: shared types and constants of the paired key table
package pkt_pkg;

  localparam int ADDR_W = 48;
  localparam int KEY_W  = 64;
  localparam int KIND_W = 8;
  localparam int SEL_W  = 8;
  localparam int SLOT_W = 3;
  localparam int CNT_W  = 4;
  localparam int OP_W   = 3;

  // operation codes
  localparam logic [OP_W-1:0] OP_LOOKUP = 3'd0;
  localparam logic [OP_W-1:0] OP_STORE  = 3'd1;
  localparam logic [OP_W-1:0] OP_DELETE = 3'd2;
  localparam logic [OP_W-1:0] OP_DELALL = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  localparam logic [KIND_W-1:0] KIND_MISS = 8'hFF;
  localparam logic [CNT_W-1:0]  CNT_MAX   = 4'd15;

  // one table entry as held in the entry memory
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [KEY_W-1:0]  key_upper;
    logic [KEY_W-1:0]  key_lower;
    logic [KIND_W-1:0] kind;
  } entry_t;

  // one result word
  typedef struct packed {
    logic              hit;
    logic [KEY_W-1:0]  found_key_upper;
    logic [KEY_W-1:0]  found_key_lower;
    logic [KIND_W-1:0] found_kind;
    logic [ADDR_W-1:0] found_addr;
    logic [SLOT_W-1:0] slot_used;
    logic              evicted;
    logic [CNT_W-1:0]  valid_count;
  } result_t;

  localparam result_t RES_MISS = '{
    hit:             1'b0,
    found_key_upper: '0,
    found_key_lower: '0,
    found_kind:      KIND_MISS,
    found_addr:      '0,
    slot_used:       '0,
    evicted:         1'b0,
    valid_count:     '0
  };

endpackage

// ===== rtl/pkt_in_if.sv =====
// pkt_in_if: request channel of the paired key table
interface pkt_in_if import pkt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [ADDR_W-1:0] device_addr;
  logic [KEY_W-1:0]  key_upper;
  logic [KEY_W-1:0]  key_lower;
  logic [KIND_W-1:0] key_kind;
  logic [SEL_W-1:0]  slot_select;

  modport source (
    output valid, op, device_addr, key_upper, key_lower, key_kind, slot_select,
    input  ready
  );
  modport sink (
    input  valid, op, device_addr, key_upper, key_lower, key_kind, slot_select,
    output ready
  );
endinterface

// ===== rtl/pkt_out_if.sv =====
// pkt_out_if: result channel of the paired key table
interface pkt_out_if import pkt_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              hit;
  logic [KEY_W-1:0]  found_key_upper;
  logic [KEY_W-1:0]  found_key_lower;
  logic [KIND_W-1:0] found_kind;
  logic [ADDR_W-1:0] found_addr;
  logic [SLOT_W-1:0] slot_used;
  logic              evicted;
  logic [CNT_W-1:0]  valid_count;

  modport source (
    output valid, hit, found_key_upper, found_key_lower, found_kind, found_addr,
           slot_used, evicted, valid_count,
    input  ready
  );
  modport sink (
    input  valid, hit, found_key_upper, found_key_lower, found_kind, found_addr,
           slot_used, evicted, valid_count,
    output ready
  );
endinterface

// ===== rtl/pkt_ram.sv =====
// pkt_ram: generic single-write, single-read ram with registered read data
module pkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/paired_key_table.sv =====
// paired_key_table: address-keyed table of pairing keys with oldest-first eviction
//
//   channel    dir  handshake           contents
//   in_word    in   valid/ready         op, device_addr, key_upper, key_lower,
//                                       key_kind, slot_select
//   out_word   out  valid/ready         hit, found key halves, found_kind,
//                                       found_addr, slot_used, evicted, valid_count
//
// one request at a time; in_word.ready is high only while the sequencer is idle
// lookup, delete and store walk the entry memory one slot a cycle through its
// single read port, all N = TABLE_ENTRIES slots on a miss and fewer on an early hit
// store adds a write of the new entry, and a shift of the table down first when full
// read slot fetches the selected slot right away; delete all and unknown ops go straight to the finish step
// reset clears the valid bits and the count; entry data is left as is
// a finished result waits in the output register; a new request is taken meanwhile
module paired_key_table import pkt_pkg::*; #(
  parameter int TABLE_ENTRIES = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  pkt_in_if.sink    in_word,
  pkt_out_if.source out_word
);

  localparam int IW = $clog2(TABLE_ENTRIES);       // slot index width
  localparam int CW = $clog2(TABLE_ENTRIES + 1);   // walk counter, reaches N
  localparam logic [CW-1:0] N_CNT   = CW'(TABLE_ENTRIES);
  localparam logic [IW-1:0] LAST    = IW'(TABLE_ENTRIES - 1);
  localparam logic [SEL_W-1:0] N_SEL = SEL_W'(TABLE_ENTRIES);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;  // walk slots for an address match
  localparam logic [2:0] S_WR    = 3'd2;  // write the new entry
  localparam logic [2:0] S_SHIFT = 3'd3;  // move every entry down one slot
  localparam logic [2:0] S_RSLOT = 3'd4;  // read slot data returns
  localparam logic [2:0] S_FIN   = 3'd5;  // hand the result to the output register

  // control state
  logic [2:0]               state_r, state_nxt;
  logic [TABLE_ENTRIES-1:0] valid_r, valid_nxt;
  logic [CW-1:0]            cnt_r, cnt_nxt;
  logic [CW-1:0]            scan_idx_r, scan_idx_nxt;   // next slot to read
  logic [IW-1:0]            cmp_idx_r, cmp_idx_nxt;     // slot whose data is on the ram output
  logic                     cmp_vld_r, cmp_vld_nxt;
  logic                     free_found_r, free_found_nxt;
  logic [IW-1:0]            free_idx_r, free_idx_nxt;
  logic [IW-1:0]            wr_idx_r, wr_idx_nxt;
  logic                     ev_r, ev_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // request and result payload
  logic [OP_W-1:0]   op_r;
  logic [ADDR_W-1:0] addr_r;
  logic [KEY_W-1:0]  ku_r;
  logic [KEY_W-1:0]  kl_r;
  logic [KIND_W-1:0] kind_r;
  logic [IW-1:0]     sel_r;
  logic              sel_ok_r;
  result_t           res_r, res_nxt;
  result_t           out_r, out_nxt;

  // entry memory ports
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  entry_t        ram_wdata;
  logic [IW-1:0] ram_raddr;
  entry_t        ram_rdata;

  logic          in_accept;
  logic          out_load;
  logic          hit_now;
  logic [7:0]    cnt_ext;
  logic [CNT_W-1:0] cnt_sat;

  pkt_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_entries (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign in_word.ready = (state_r == S_IDLE);
  assign in_accept     = in_word.valid && in_word.ready;

  // valid entry whose address matches the request
  assign hit_now = cmp_vld_r && valid_r[cmp_idx_r] && (ram_rdata.addr == addr_r);

  // count saturates at 15 for large tables
  assign cnt_ext = 8'(cnt_r);
  assign cnt_sat = (cnt_ext > 8'(CNT_MAX)) ? CNT_MAX : cnt_ext[CNT_W-1:0];

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    scan_idx_nxt   = scan_idx_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    wr_idx_nxt     = wr_idx_r;
    ev_nxt         = ev_r;
    res_nxt        = res_r;
    out_load       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = wr_idx_r;
    ram_wdata      = '{addr: addr_r, key_upper: ku_r, key_lower: kl_r, kind: kind_r};
    ram_raddr      = scan_idx_r[IW-1:0];

    // result word with the count after this request
    out_nxt             = res_r;
    out_nxt.valid_count = cnt_sat;

    // output register drains on its own handshake
    out_valid_nxt = out_valid_r && !out_word.ready;

    unique case (state_r)
      S_IDLE: begin
        // read slot data is fetched right away
        ram_raddr = in_word.slot_select[IW-1:0];
        if (in_accept) begin
          scan_idx_nxt   = '0;
          free_found_nxt = 1'b0;
          ev_nxt         = 1'b0;
          unique case (in_word.op) inside
            OP_LOOKUP, OP_STORE, OP_DELETE: begin
              state_nxt = S_SCAN;
            end
            OP_DELALL: begin
              valid_nxt         = '0;
              cnt_nxt           = '0;
              res_nxt           = RES_MISS;
              res_nxt.hit       = 1'b1;
              res_nxt.found_kind = '0;
              state_nxt         = S_FIN;
            end
            OP_READ: begin
              state_nxt = S_RSLOT;
            end
            default: begin
              res_nxt   = RES_MISS;
              state_nxt = S_FIN;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit_now) begin
          unique case (op_r)
            OP_LOOKUP: begin
              res_nxt                 = RES_MISS;
              res_nxt.hit             = 1'b1;
              res_nxt.found_key_upper = ram_rdata.key_upper;
              res_nxt.found_key_lower = ram_rdata.key_lower;
              res_nxt.found_kind      = ram_rdata.kind;
              res_nxt.slot_used       = SLOT_W'(cmp_idx_r);
              state_nxt               = S_FIN;
            end
            OP_DELETE: begin
              valid_nxt[cmp_idx_r] = 1'b0;
              cnt_nxt              = cnt_r - CW'(1);
              res_nxt              = RES_MISS;
              res_nxt.hit          = 1'b1;
              res_nxt.found_kind   = '0;
              res_nxt.slot_used    = SLOT_W'(cmp_idx_r);
              state_nxt            = S_FIN;
            end
            default: begin
              // store onto the matching entry
              wr_idx_nxt = cmp_idx_r;
              state_nxt  = S_WR;
            end
          endcase
        end else if (scan_idx_r != N_CNT) begin
          ram_raddr    = scan_idx_r[IW-1:0];
          cmp_idx_nxt  = scan_idx_r[IW-1:0];
          cmp_vld_nxt  = 1'b1;
          scan_idx_nxt = scan_idx_r + CW'(1);
          if (!valid_r[scan_idx_r[IW-1:0]] && !free_found_r) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = scan_idx_r[IW-1:0];
          end
        end else if (op_r == OP_STORE) begin
          if (free_found_r) begin
            wr_idx_nxt = free_idx_r;
            state_nxt  = S_WR;
          end else begin
            // table full: shift down, slot 0 falls out
            scan_idx_nxt = CW'(1);
            state_nxt    = S_SHIFT;
          end
        end else begin
          res_nxt   = RES_MISS;
          state_nxt = S_FIN;
        end
      end

      S_SHIFT: begin
        if (cmp_vld_r) begin
          ram_we    = 1'b1;
          ram_waddr = cmp_idx_r - IW'(1);
          ram_wdata = ram_rdata;
        end
        if (scan_idx_r != N_CNT) begin
          ram_raddr    = scan_idx_r[IW-1:0];
          cmp_idx_nxt  = scan_idx_r[IW-1:0];
          cmp_vld_nxt  = 1'b1;
          scan_idx_nxt = scan_idx_r + CW'(1);
        end else begin
          wr_idx_nxt = LAST;
          ev_nxt     = 1'b1;
          state_nxt  = S_WR;
        end
      end

      S_WR: begin
        ram_we    = 1'b1;
        ram_waddr = wr_idx_r;
        if (!valid_r[wr_idx_r]) begin
          valid_nxt[wr_idx_r] = 1'b1;
          cnt_nxt             = cnt_r + CW'(1);
        end
        res_nxt            = RES_MISS;
        res_nxt.hit        = 1'b1;
        res_nxt.found_kind = '0;
        res_nxt.slot_used  = SLOT_W'(wr_idx_r);
        res_nxt.evicted    = ev_r;
        state_nxt          = S_FIN;
      end

      S_RSLOT: begin
        res_nxt = RES_MISS;
        if (sel_ok_r && valid_r[sel_r]) begin
          res_nxt.hit             = 1'b1;
          res_nxt.found_key_upper = ram_rdata.key_upper;
          res_nxt.found_key_lower = ram_rdata.key_lower;
          res_nxt.found_kind      = ram_rdata.kind;
          res_nxt.found_addr      = ram_rdata.addr;
          res_nxt.slot_used       = SLOT_W'(sel_r);
        end
        state_nxt = S_FIN;
      end

      S_FIN: begin
        if (!out_valid_r || out_word.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      cnt_r        <= '0;
      scan_idx_r   <= '0;
      cmp_idx_r    <= '0;
      cmp_vld_r    <= 1'b0;
      free_found_r <= 1'b0;
      free_idx_r   <= '0;
      wr_idx_r     <= '0;
      ev_r         <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      cnt_r        <= cnt_nxt;
      scan_idx_r   <= scan_idx_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      free_found_r <= free_found_nxt;
      free_idx_r   <= free_idx_nxt;
      wr_idx_r     <= wr_idx_nxt;
      ev_r         <= ev_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_accept) begin
      op_r     <= in_word.op;
      addr_r   <= in_word.device_addr;
      ku_r     <= in_word.key_upper;
      kl_r     <= in_word.key_lower;
      kind_r   <= in_word.key_kind;
      sel_r    <= in_word.slot_select[IW-1:0];
      sel_ok_r <= (in_word.slot_select < N_SEL);
    end
    res_r <= res_nxt;
    if (out_load) begin
      out_r <= out_nxt;
    end
  end

  assign out_word.valid           = out_valid_r;
  assign out_word.hit             = out_r.hit;
  assign out_word.found_key_upper = out_r.found_key_upper;
  assign out_word.found_key_lower = out_r.found_key_lower;
  assign out_word.found_kind      = out_r.found_kind;
  assign out_word.found_addr      = out_r.found_addr;
  assign out_word.slot_used       = out_r.slot_used;
  assign out_word.evicted         = out_r.evicted;
  assign out_word.valid_count     = out_r.valid_count;

  // running count tracks the valid bits
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == $countones(valid_r))
    else $error("valid count out of step with valid bits");

  // shifting only happens on a full table
  a_shift_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_SHIFT |-> &valid_r)
    else $error("shift started with a free slot");

  // a new result only comes from the finish step
  a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_FIN))
    else $error("result word loaded outside finish step");

  // an eviction always lands in the last slot
  a_evict_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_r.evicted |-> out_r.hit && out_r.slot_used == SLOT_W'(LAST))
    else $error("eviction result not on last slot");

  // a miss carries the miss kind and no address
  a_miss_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_r.hit |-> out_r.found_kind == KIND_MISS && out_r.found_addr == '0)
    else $error("miss result fields wrong");

endmodule
